[rtl/hbvsm_pkg.sv]
// Shared types, constants and the exp2 factor table for the HBV soil moisture step.
// Used by every module of the block; no dependencies.
package hbvsm_pkg;

  localparam int CNT_W = 5;
  localparam int CFG_W = 2;

  localparam logic [CFG_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_W-1:0] CFG_LP       = 2'd1;
  localparam logic [CFG_W-1:0] CFG_BETA     = 2'd2;

  localparam logic [31:0] CAPACITY_RST = 32'd9830400;
  localparam logic [16:0] LP_RST       = 17'd45875;
  localparam logic [15:0] BETA_RST     = 16'd8192;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_RDIV,
    ST_PCHK,
    ST_LOG,
    ST_NLO,
    ST_NHI,
    ST_EXP,
    ST_PSH,
    ST_HSW,
    ST_ET,
    ST_FDIV,
    ST_ETMUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    state_e           st;
    logic [CNT_W-1:0] cnt;
    logic             accept;
    logic             commit;
  } ctl_t;

  typedef struct packed {
    logic at_cap;
    logic pow_skip;
    logic et_full;
  } stat_t;

  typedef struct packed {
    logic [31:0] soil;
    logic [31:0] runoff;
    logic [31:0] et;
    logic [39:0] accum;
  } res_t;

  typedef logic [30:0] fac_tab_t [32];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] xx;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    xx  = x;
    for (int i = 0; i < 32; i++) begin
      if (b > xx) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (xx >= res + b) begin
          xx  = xx - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // fac[k] = 2^-(2^-(k+1)) in Q1.30, by repeated integer roots
  function automatic fac_tab_t build_fac();
    fac_tab_t    t;
    logic [63:0] f;
    f    = isqrt64(64'd1 << 59);
    t[0] = f[30:0];
    for (int k = 1; k < 32; k++) begin
      f    = isqrt64(f << 30);
      t[k] = f[30:0];
    end
    return t;
  endfunction

  localparam fac_tab_t FAC = build_fac();

endpackage

[rtl/hbv_soil_moisture_step.sv]
// HBV soil moisture step, one simulated day per item, one result per item.
// Shortest path from accept to registered result when soil is at capacity and ET is
// unlimited; the longest path is set by the two 16-step divisions and the log2/exp2
// loops on the shared multiplier. One item in flight; next item accepted in the cycle
// after its result is registered, and result stalls delay it. Reset: stores zero,
// registers at defaults.
module hbv_soil_moisture_step import hbvsm_pkg::*; #(
  parameter int POW_ITERATIONS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [31:0]      precip_in_i,
  input  logic [31:0]      pet_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      soil_level_o,
  output logic [31:0]      runoff_out_o,
  output logic [31:0]      actual_et_o,
  output logic [39:0]      runoff_accum_o
);

  logic [31:0] cap_q;
  logic [16:0] lp_q;
  logic [15:0] beta_q;
  logic        out_valid_q;
  res_t        out_q;
  res_t        res;
  stat_t       stat;
  ctl_t        ctl;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  hbvsm_ctrl #(.POW_ITERATIONS(POW_ITERATIONS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  hbvsm_dp #(.POW_ITERATIONS(POW_ITERATIONS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .capacity_i  (cap_q),
    .lp_i        (lp_q),
    .beta_i      (beta_q),
    .precip_in_i (precip_in_i),
    .pet_i       (pet_i),
    .stat_o      (stat),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAPACITY_RST;
      lp_q   <= LP_RST;
      beta_q <= BETA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY: cap_q  <= cfg_data_i;
        CFG_LP:       lp_q   <= cfg_data_i[16:0];
        CFG_BETA:     beta_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) out_q <= res;
  end

  assign in_stall_o     = (ctl.st != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign soil_level_o   = out_q.soil;
  assign runoff_out_o   = out_q.runoff;
  assign actual_et_o    = out_q.et;
  assign runoff_accum_o = out_q.accum;

endmodule

[rtl/hbvsm_ctrl.sv]
// Sequencer of the HBV soil moisture step: state, step counter, accept and commit.
// Depends on hbvsm_pkg.
module hbvsm_ctrl import hbvsm_pkg::*; #(
  parameter int POW_ITERATIONS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  localparam int N = (POW_ITERATIONS > 32) ? 32 : POW_ITERATIONS;
  localparam logic [CNT_W-1:0] LAST_POW = CNT_W'(N - 1);
  localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(15);

  state_e           st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;

  always_comb begin
    case (st_q)
      ST_RDIV, ST_FDIV: last = (cnt_q == LAST_DIV);
      ST_LOG, ST_EXP:   last = (cnt_q == LAST_POW);
      default:          last = 1'b0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_valid_i) st_d = ST_DEN;
      ST_DEN:   st_d = stat_i.at_cap ? ST_ET : ST_RDIV;
      ST_RDIV:  if (last) st_d = ST_PCHK;
      ST_PCHK:  st_d = stat_i.pow_skip ? ST_HSW : ST_LOG;
      ST_LOG:   if (last) st_d = ST_NLO;
      ST_NLO:   st_d = ST_NHI;
      ST_NHI:   st_d = ST_EXP;
      ST_EXP:   if (last) st_d = ST_PSH;
      ST_PSH:   st_d = ST_HSW;
      ST_HSW:   st_d = ST_ET;
      ST_ET:    st_d = stat_i.et_full ? ST_DONE : ST_FDIV;
      ST_FDIV:  if (last) st_d = ST_ETMUL;
      ST_ETMUL: st_d = ST_DONE;
      ST_DONE:  if (out_free_i) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d         = (st_d != st_q) ? '0 : cnt_q + CNT_W'(1);
    ctl_o.st      = st_q;
    ctl_o.cnt     = cnt_q;
    ctl_o.accept  = (st_q == ST_IDLE) && in_valid_i;
    ctl_o.commit  = (st_q == ST_DONE) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/hbvsm_dp.sv]
// Datapath of the HBV soil moisture step: shared 32x32 multiplier, shared divider
// subtractor, working registers and the soil and runoff stores. Depends on hbvsm_pkg.
module hbvsm_dp import hbvsm_pkg::*; #(
  parameter int POW_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  logic [31:0] capacity_i,
  input  logic [16:0] lp_i,
  input  logic [15:0] beta_i,
  input  logic [31:0] precip_in_i,
  input  logic [31:0] pet_i,
  output stat_t       stat_o,
  output res_t        res_o
);

  localparam int N   = (POW_ITERATIONS > 32) ? 32 : POW_ITERATIONS;
  localparam int NLW = N + 5;

  logic [31:0]  soil_q, soil_d;
  logic [39:0]  store_q, store_d;
  logic [31:0]  precip_q, precip_d;
  logic [31:0]  pet_q, pet_d;
  logic [48:0]  denom_q, denom_d;
  logic [49:0]  rem_q, rem_d;
  logic [15:0]  quo_q, quo_d;
  logic [3:0]   p_q, p_d;
  logic [30:0]  m_q, m_d;
  logic [N-1:0] frac_q, frac_d;
  logic [47:0]  acc_q, acc_d;
  logic [41:0]  e_q, e_d;
  logic [N-1:0] fp_q, fp_d;
  logic [30:0]  v_q, v_d;
  logic [16:0]  pw_q, pw_d;
  logic [31:0]  sw_q, sw_d;
  logic [32:0]  run_q, run_d;
  logic [31:0]  dem_q, dem_d;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [49:0]  dv, dt;
  logic         dge;
  logic [3:0]   p_enc;
  logic [NLW-1:0] neglog;
  logic [63:0]  nl64;
  logic [53:0]  esum;
  logic [31:0]  sq;
  logic [30:0]  et_t;
  logic         ebig;
  logic [4:0]   sh;
  logic [31:0]  hsw;
  logic [32:0]  soil_t, run_t;
  logic [31:0]  taken, soil_new, run32;
  logic [40:0]  store_sum;

  always_comb begin
    p_enc = '0;
    for (int k = 0; k < 16; k++) begin
      if (quo_q[k]) p_enc = 4'(k);
    end
  end

  assign neglog = (NLW'(5'd16 - {1'b0, p_q}) << N) - NLW'(frac_q);
  assign nl64   = 64'(neglog);

  always_comb begin
    case (ctl_i.st)
      ST_DEN:   begin mul_a = capacity_i;      mul_b = 32'(lp_i);              end
      ST_LOG:   begin mul_a = 32'(m_q);        mul_b = 32'(m_q);               end
      ST_NLO:   begin mul_a = nl64[31:0];      mul_b = 32'(beta_i);            end
      ST_NHI:   begin mul_a = nl64[63:32];     mul_b = 32'(beta_i);            end
      ST_EXP:   begin mul_a = 32'(v_q);        mul_b = 32'(FAC[ctl_i.cnt]);    end
      ST_HSW:   begin mul_a = precip_q;        mul_b = 32'(17'h10000 - pw_q);  end
      ST_ETMUL: begin mul_a = pet_q;           mul_b = 32'(quo_q);             end
      default:  begin mul_a = '0;              mul_b = '0;                     end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  assign dv  = (ctl_i.st == ST_RDIV) ? 50'(capacity_i) : 50'(denom_q);
  assign dt  = {rem_q[48:0], 1'b0};
  assign dge = (dt >= dv);

  assign esum = 54'(acc_q) + (54'(prod[20:0]) << 32);
  assign sq   = prod[61:30];
  assign et_t = prod[60:30];
  assign ebig = (e_q >> N) > 42'd16;
  assign sh   = 5'd14 + e_q[N +: 5];
  assign hsw  = prod[47:16];

  assign soil_t = 33'(soil_q) + 33'(hsw);
  assign run_t  = 33'(precip_q) - 33'(hsw);

  assign stat_o.at_cap   = (soil_q >= capacity_i);
  assign stat_o.pow_skip = (beta_i == 16'd0) || (quo_q == 16'd0);
  assign stat_o.et_full  = (denom_q == 49'd0) || ({1'b0, soil_q, 16'h0} >= denom_q);

  assign taken     = (sw_q > dem_q) ? dem_q : sw_q;
  assign soil_new  = sw_q - taken;
  assign run32     = run_q[32] ? 32'hFFFF_FFFF : run_q[31:0];
  assign store_sum = 41'(store_q) + 41'(run32);

  assign res_o.soil   = soil_new;
  assign res_o.runoff = run32;
  assign res_o.et     = taken;
  assign res_o.accum  = store_sum[40] ? 40'hFF_FFFF_FFFF : store_sum[39:0];

  always_comb begin
    soil_d   = soil_q;
    store_d  = store_q;
    precip_d = precip_q;
    pet_d    = pet_q;
    denom_d  = denom_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    p_d      = p_q;
    m_d      = m_q;
    frac_d   = frac_q;
    acc_d    = acc_q;
    e_d      = e_q;
    fp_d     = fp_q;
    v_d      = v_q;
    pw_d     = pw_q;
    sw_d     = sw_q;
    run_d    = run_q;
    dem_d    = dem_q;
    if (ctl_i.accept) begin
      precip_d = precip_in_i;
      pet_d    = pet_i;
    end
    case (ctl_i.st)
      ST_DEN: begin
        denom_d = prod[48:0];
        rem_d   = 50'(soil_q);
        quo_d   = '0;
        sw_d    = capacity_i;
        run_d   = 33'(precip_q) + 33'(soil_q - capacity_i);
      end
      ST_RDIV, ST_FDIV: begin
        rem_d = dge ? dt - dv : dt;
        quo_d = {quo_q[14:0], dge};
      end
      ST_PCHK: begin
        pw_d   = (beta_i == 16'd0) ? 17'h10000 : 17'd0;
        p_d    = p_enc;
        m_d    = 31'(quo_q) << (5'd30 - {1'b0, p_enc});
        frac_d = '0;
      end
      ST_LOG: begin
        m_d    = sq[31] ? sq[31:1] : sq[30:0];
        frac_d = {frac_q[N-2:0], sq[31]};
      end
      ST_NLO: acc_d = prod[47:0];
      ST_NHI: begin
        e_d  = esum[53:12];
        fp_d = esum[N+11:12];
        v_d  = 31'h4000_0000;
      end
      ST_EXP: begin
        v_d  = fp_q[N-1] ? et_t : v_q;
        fp_d = fp_q << 1;
      end
      ST_PSH: pw_d = ebig ? 17'd0 : 17'(v_q >> sh);
      ST_HSW: begin
        if (soil_t > 33'(capacity_i)) begin
          sw_d  = capacity_i;
          run_d = run_t + (soil_t - 33'(capacity_i));
        end else begin
          sw_d  = soil_t[31:0];
          run_d = run_t;
        end
      end
      ST_ET: begin
        dem_d = pet_q;
        rem_d = 50'({soil_q, 16'h0});
        quo_d = '0;
      end
      ST_ETMUL: dem_d = prod[47:16];
      default: ;
    endcase
    if (ctl_i.commit) begin
      soil_d  = res_o.soil;
      store_d = res_o.accum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soil_q  <= '0;
      store_q <= '0;
    end else begin
      soil_q  <= soil_d;
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i) begin
    precip_q <= precip_d;
    pet_q    <= pet_d;
    denom_q  <= denom_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    p_q      <= p_d;
    m_q      <= m_d;
    frac_q   <= frac_d;
    acc_q    <= acc_d;
    e_q      <= e_d;
    fp_q     <= fp_d;
    v_q      <= v_d;
    pw_q     <= pw_d;
    sw_q     <= sw_d;
    run_q    <= run_d;
    dem_q    <= dem_d;
  end

endmodule

[rtl/hbvsm_chk.sv]
// Port-level checker for hbv_soil_moisture_step, attached by bind.
// Depends on hbvsm_pkg.
module hbvsm_chk import hbvsm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [CFG_W-1:0] cfg_idx_i,
  input logic [31:0]      cfg_data_i,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [31:0]      precip_in_i,
  input logic [31:0]      pet_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [31:0]      soil_level_o,
  input logic [31:0]      runoff_out_o,
  input logic [31:0]      actual_et_o,
  input logic [39:0]      runoff_accum_o
);

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after item accept");

  // a new result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(soil_level_o)
      && $stable(runoff_out_o) && $stable(actual_et_o) && $stable(runoff_accum_o))
    else $error("stalled result changed");

  // ET taken plus soil after the day never exceeds 2^33-1
  a_et_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (64'(actual_et_o) + 64'(soil_level_o)) <= 64'h1_FFFF_FFFF)
    else $error("soil plus ET out of range");

endmodule

bind hbv_soil_moisture_step hbvsm_chk u_chk (.*);
